// File: rtl/core/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

   // Field widths of the channels and of the configuration port.
   localparam int BYTE_W      = 8;
   localparam int HASH_W      = 31;
   localparam int LEN_W       = 32;
   localparam int SEEN_W      = 9;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // Block hash modulus, 2^31 - 1.
   localparam logic [HASH_W-1:0] HASH_MODULUS = 31'h7FFF_FFFF;
   localparam logic [LEN_W-1:0]  LENGTH_MAX   = 32'hFFFF_FFFF;

   // Smallest legal window-hash modulus.
   localparam logic [BYTE_W-1:0] FACTOR_MIN = 8'd3;

   // The serial remainder units walk one dividend bit per cycle over a 16-bit dividend.
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FACTOR         = 1'b0,
      CSR_REMOVAL_WEIGHT = 1'b1
   } rhc_csr_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } rhc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic load;
      logic step;
      logic commit;
   } rhc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic factor_ok;
      logic emit;
      logic rsp_free;
   } rhc_status_type;

endpackage

// File: rtl/core/rhc_req_if.sv
`timescale 1ns / 1ps

interface rhc_req_if
   import rhc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// File: rtl/core/rhc_rsp_if.sv
`timescale 1ns / 1ps

interface rhc_rsp_if
   import rhc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] chunk_hash;
   logic [LEN_W-1:0]  chunk_length;
   logic              config_error;

   modport source (output valid, chunk_hash, chunk_length, config_error, input ready);
   modport sink   (input valid, chunk_hash, chunk_length, config_error, output ready);
endinterface

// File: rtl/core/rhc_ram.sv
`timescale 1ns / 1ps

module rhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;
endmodule

// File: rtl/core/rhc_ctrl.sv
`timescale 1ns / 1ps

module rhc_ctrl
   import rhc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rhc_status_type status,
   output rhc_cmd_type    cmd
);
   rhc_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic                   accept;
   logic                   last_step;
   logic                   can_commit;

   assign accept     = (state_ff == ST_IDLE) && req_valid;
   assign last_step  = (count_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign can_commit = !status.emit || status.rsp_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = status.factor_ok ? ST_LOAD : ST_FINISH;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (can_commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and the step counter.
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      count_in   = count_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = accept;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            count_in = '0;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            count_in = count_ff + DIV_CNT_W'(1);
         end
         ST_FINISH: begin
            cmd.commit = can_commit;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end
endmodule

// File: rtl/core/rhc_datapath.sv
`timescale 1ns / 1ps

module rhc_datapath
   import rhc_pkg::*;
#(
   parameter int MAX_WINDOW = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rhc_cmd_type            cmd,
   output rhc_status_type         status,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic                   req_last_byte,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [HASH_W-1:0]      rsp_chunk_hash,
   output logic [LEN_W-1:0]       rsp_chunk_length,
   output logic                   rsp_config_error
);
   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int CMP_W = (PTR_W + 1 > SEEN_W) ? PTR_W + 1 : SEEN_W;

   // Configuration registers.
   logic [BYTE_W-1:0]   factor_ff;
   logic [BYTE_W-1:0]   weight_ff;

   // Stream state.
   logic [BYTE_W-1:0]   window_sum_ff;
   logic [HASH_W-1:0]   chunk_sum_ff;
   logic [SEEN_W-1:0]   bytes_seen_ff;
   logic [LEN_W-1:0]    run_length_ff;
   logic [PTR_W-1:0]    pos_ff;

   // Latched input beat and remainder unit state.
   logic [BYTE_W-1:0]   byte_ff;
   logic                last_ff;
   logic [2*BYTE_W-1:0] x_shift_ff;
   logic [2*BYTE_W-1:0] y_shift_ff;
   logic [BYTE_W-1:0]   rem_x_ff;
   logic [BYTE_W-1:0]   rem_y_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [HASH_W-1:0]   rsp_hash_ff;
   logic [LEN_W-1:0]    rsp_length_ff;
   logic                rsp_error_ff;

   logic [BYTE_W-1:0]   old_byte;
   logic                factor_ok;
   logic [SEEN_W-1:0]   window_len;
   logic                full_before;
   logic [BYTE_W:0]     diff;
   logic [BYTE_W-1:0]   window_next;
   logic [SEEN_W-1:0]   seen_next;
   logic                full_after;
   logic [PTR_W:0]      pos_plus;
   logic [PTR_W-1:0]    pos_next;
   logic [LEN_W-1:0]    chunk_wide;
   logic [HASH_W-1:0]   chunk_next;
   logic [LEN_W-1:0]    run_next;
   logic                emit;

   // One restoring remainder step: shift in a dividend bit, subtract the modulus if it fits.
   function automatic logic [BYTE_W-1:0] rem_step(input logic [BYTE_W-1:0] rem,
                                                  input logic             dividend_bit,
                                                  input logic [BYTE_W-1:0] modulus);
      logic [BYTE_W:0] shifted;
      logic [BYTE_W:0] reduced;
      shifted = {rem, dividend_bit};
      reduced = shifted - {1'b0, modulus};
      if (shifted >= {1'b0, modulus}) begin
         return reduced[BYTE_W-1:0];
      end
      return shifted[BYTE_W-1:0];
   endfunction

   // Window byte store, read at the current ring position.
   rhc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_WINDOW)
   ) u_window_ram (
      .clock         (clock),
      .write_enable  (cmd.commit && factor_ok),
      .write_address (pos_ff),
      .write_data    (byte_ff),
      .read_address  (pos_ff),
      .read_data     (old_byte)
   );

   assign factor_ok  = factor_ff[0] && (factor_ff >= FACTOR_MIN);
   assign window_len = {1'b0, factor_ff} + SEEN_W'(1);
   assign full_before = (bytes_seen_ff >= window_len);

   // Window hash: remainder of the shifted sum minus remainder of the leaving byte's weight.
   always_comb begin
      diff = {1'b0, rem_x_ff} - {1'b0, (full_before ? rem_y_ff : '0)};
      if (diff[BYTE_W]) begin
         window_next = diff[BYTE_W-1:0] + factor_ff;
      end else begin
         window_next = diff[BYTE_W-1:0];
      end
   end

   // Fill count and ring position.
   always_comb begin
      seen_next  = full_before ? bytes_seen_ff : bytes_seen_ff + SEEN_W'(1);
      full_after = (seen_next >= window_len);
      pos_plus   = {1'b0, pos_ff} + (PTR_W + 1)'(1);
      if ((CMP_W'(pos_plus) >= CMP_W'(window_len)) ||
          (CMP_W'(pos_plus) >= CMP_W'(MAX_WINDOW))) begin
         pos_next = '0;
      end else begin
         pos_next = pos_plus[PTR_W-1:0];
      end
   end

   // Block hash: 2^31 folds to 1 modulo 2^31-1, so the top byte adds back in at the bottom.
   always_comb begin
      chunk_wide = {1'b0, chunk_sum_ff[HASH_W-9:0], 8'h00}
                 + LEN_W'(chunk_sum_ff[HASH_W-1:HASH_W-8])
                 + LEN_W'(byte_ff);
      if (chunk_wide >= {1'b0, HASH_MODULUS}) begin
         chunk_next = HASH_W'(chunk_wide - {1'b0, HASH_MODULUS});
      end else begin
         chunk_next = chunk_wide[HASH_W-1:0];
      end
      run_next = (run_length_ff == LENGTH_MAX) ? run_length_ff : run_length_ff + LEN_W'(1);
   end

   // Result decision.
   always_comb begin
      if (factor_ok) begin
         emit = last_ff || (full_after && (window_next == factor_ff - BYTE_W'(1)));
      end else begin
         emit = last_ff;
      end
   end

   assign status.factor_ok = factor_ok;
   assign status.emit      = emit;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Input beat capture and the two serial remainder units.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         byte_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
      if (cmd.load) begin
         x_shift_ff <= {window_sum_ff, byte_ff};
         y_shift_ff <= (2*BYTE_W)'(old_byte) * (2*BYTE_W)'(weight_ff);
         rem_x_ff   <= '0;
         rem_y_ff   <= '0;
      end else if (cmd.step) begin
         x_shift_ff <= {x_shift_ff[2*BYTE_W-2:0], 1'b0};
         y_shift_ff <= {y_shift_ff[2*BYTE_W-2:0], 1'b0};
         rem_x_ff   <= rem_step(rem_x_ff, x_shift_ff[2*BYTE_W-1], factor_ff);
         rem_y_ff   <= rem_step(rem_y_ff, y_shift_ff[2*BYTE_W-1], factor_ff);
      end
   end

   // Configuration and stream state.
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff     <= FACTOR_MIN;
         weight_ff     <= BYTE_W'(1);
         window_sum_ff <= '0;
         chunk_sum_ff  <= '0;
         bytes_seen_ff <= '0;
         run_length_ff <= '0;
         pos_ff        <= '0;
      end else if (csr_write_enable) begin
         case (rhc_csr_type'(csr_index))
            CSR_FACTOR: begin
               factor_ff     <= csr_write_data;
               window_sum_ff <= '0;
               bytes_seen_ff <= '0;
               pos_ff        <= '0;
            end
            CSR_REMOVAL_WEIGHT: begin
               weight_ff <= csr_write_data;
            end
            default: begin
               weight_ff <= weight_ff;
            end
         endcase
      end else if (cmd.commit) begin
         if (last_ff) begin
            window_sum_ff <= '0;
            chunk_sum_ff  <= '0;
            bytes_seen_ff <= '0;
            run_length_ff <= '0;
            pos_ff        <= '0;
         end else if (factor_ok) begin
            window_sum_ff <= window_next;
            bytes_seen_ff <= seen_next;
            pos_ff        <= pos_next;
            chunk_sum_ff  <= emit ? '0 : chunk_next;
            run_length_ff <= emit ? '0 : run_next;
         end
      end
   end

   // Output register: holds a finished beat until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && emit) begin
         rsp_hash_ff   <= factor_ok ? chunk_next : '0;
         rsp_length_ff <= factor_ok ? run_next : '0;
         rsp_error_ff  <= !factor_ok;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chunk_hash   = rsp_hash_ff;
   assign rsp_chunk_length = rsp_length_ff;
   assign rsp_config_error = rsp_error_ff;
endmodule

// File: rtl/core/rolling_hash_chunker_unit.sv
`timescale 1ns / 1ps
// The block takes a new byte only while idle, once the last byte is committed. Each byte
// is latched, loaded into the 16-step serial remainder units, divided and committed.
// With an invalid factor a byte skips loading and dividing. A waiting result stalls the next
// byte only when that byte also closes a block. Reset is synchronous and active high; it
// restores factor 3 and removal weight 1 and clears the stream state, not the window store.

module rolling_hash_chunker_unit
   import rhc_pkg::*;
#(
   parameter int MAX_WINDOW = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   rhc_req_if.sink                req_ch,
   rhc_rsp_if.source              rsp_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);
   rhc_cmd_type    cmd;
   rhc_status_type status;

   // Sequencer.
   rhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hash datapath.
   rhc_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data_byte    (req_ch.data_byte),
      .req_last_byte    (req_ch.last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_chunk_hash   (rsp_ch.chunk_hash),
      .rsp_chunk_length (rsp_ch.chunk_length),
      .rsp_config_error (rsp_ch.config_error)
   );
endmodule

// File: bench/rolling_hash_chunker_unit_test.sv
`timescale 1ns / 1ps

module rolling_hash_chunker_unit_test;
   import rhc_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CALM_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD    = 1500;
   localparam int HOLD_AFTER   = 30;
   localparam int WINDOW_SLOTS = 256;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } byte_beat_t;

   typedef struct packed {
      logic [HASH_W-1:0] hash;
      logic [LEN_W-1:0]  length;
      logic              err;
   } chunk_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   rhc_req_if req_ch ();
   rhc_rsp_if rsp_ch ();

   rolling_hash_chunker_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Stimulus and scoreboard state.
   byte_beat_t    bytes_pending[$];
   chunk_result_t chunks_due[$];
   int  pushed_count   = 0;
   int  accepted_count = 0;
   int  chunks_seen    = 0;
   int  failures       = 0;
   bit  calm           = 1'b0;

   // Predicted copy of the block's registers and stream state.
   int unsigned cur_factor = 3;
   int unsigned cur_weight = 1;
   int unsigned window_mem[WINDOW_SLOTS];
   int unsigned win_sum    = 0;
   int unsigned fill_count = 0;
   int unsigned ring_pos   = 0;
   longint unsigned chunk_acc = 0;
   logic [LEN_W-1:0] run_len = '0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready     = 1'b0;
   end

   function automatic bit factor_ok(int unsigned f);
      return (f % 2 == 1) && (f >= FACTOR_MIN);
   endfunction

   // Weight that takes the oldest byte out of a full window: 256^(f+1) mod f.
   function automatic int unsigned exit_weight(int unsigned f);
      int unsigned w;
      w = 1;
      repeat (f + 1) w = (w * 256) % f;
      return w;
   endfunction

   task automatic clear_window();
      win_sum    = 0;
      fill_count = 0;
      ring_pos   = 0;
   endtask

   task automatic clear_stream();
      clear_window();
      chunk_acc = 0;
      run_len   = '0;
   endtask

   // Advances the predicted state by one byte and queues the block it closes, if any.
   task automatic hash_byte(input logic [BYTE_W-1:0] b, input logic last);
      chunk_result_t r;
      int unsigned wlen, t, sub, pos;
      bit closes;
      if (!factor_ok(cur_factor)) begin
         if (last) begin
            r.hash   = '0;
            r.length = '0;
            r.err    = 1'b1;
            chunks_due.push_back(r);
            clear_stream();
         end
         return;
      end
      wlen = cur_factor + 1;
      pos  = ring_pos;
      if (pos >= wlen || pos >= WINDOW_SLOTS) pos = 0;
      t = (win_sum * 256 + b) % cur_factor;
      if (fill_count >= wlen) begin
         sub = (window_mem[pos] * cur_weight) % cur_factor;
         t   = (t + cur_factor - sub) % cur_factor;
      end
      win_sum        = t;
      window_mem[pos] = b;
      pos++;
      if (pos >= wlen || pos >= WINDOW_SLOTS) pos = 0;
      ring_pos = pos;
      if (fill_count < wlen) fill_count++;
      chunk_acc = ((chunk_acc << 8) + b) % 64'd2147483647;
      if (run_len != LENGTH_MAX) run_len++;
      closes = (win_sum == cur_factor - 1 && fill_count >= wlen) || last;
      if (!closes) return;
      r.hash   = chunk_acc[HASH_W-1:0];
      r.length = run_len;
      r.err    = 1'b0;
      chunks_due.push_back(r);
      chunk_acc = 0;
      run_len   = '0;
      if (last) clear_stream();
   endtask

   // Register write; the block is idle whenever this is called.
   task automatic write_csr(input rhc_csr_type idx, input int unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_FACTOR) begin
         cur_factor = value & 8'hFF;
         clear_window();
      end else begin
         cur_weight = value & 8'hFF;
      end
   endtask

   task automatic push_byte(input int unsigned b, input bit last);
      byte_beat_t beat;
      beat.data = b[BYTE_W-1:0];
      beat.last = last;
      bytes_pending.push_back(beat);
      pushed_count++;
   endtask

   // One data set of random bytes, now and then with a stray last flag inside.
   task automatic push_set(input int len, input bit close);
      for (int i = 0; i < len; i++) begin
         if (i == len - 1) push_byte($urandom_range(0, 255), close);
         else push_byte($urandom_range(0, 255), $urandom_range(0, 29) == 0);
      end
   endtask

   // Waits until every byte is taken and every block has come out, then lets the
   // pipeline run dry in case the last bytes closed nothing.
   task automatic drain();
      do @(negedge clock);
      while (accepted_count != pushed_count || chunks_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_factor(input int unsigned f, input bit fit_weight);
      write_csr(CSR_FACTOR, f);
      if (fit_weight && factor_ok(f)) write_csr(CSR_REMOVAL_WEIGHT, exit_weight(f));
   endtask

   // Request driver: presents queued beats, with random gaps between them.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            hash_byte(req_ch.data_byte, req_ch.last_byte);
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 17);
               req_ch.valid <= 1'b0;
            end else if (bytes_pending.size() != 0) begin
               byte_beat_t beat;
               beat = bytes_pending.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= beat.data;
               req_ch.last_byte <= beat.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and ready control, with one long hold-off to back up the block.
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            chunks_seen++;
            if (chunks_due.size() == 0) begin
               $display("%0t unexpected result beat: hash %h length %h error %b", $time,
                        rsp_ch.chunk_hash, rsp_ch.chunk_length, rsp_ch.config_error);
               failures++;
            end else begin
               chunk_result_t want;
               want = chunks_due.pop_front();
               if (rsp_ch.chunk_hash !== want.hash) begin
                  $display("%0t chunk_hash mismatch: expected %h, actual %h", $time,
                           want.hash, rsp_ch.chunk_hash);
                  failures++;
               end
               if (rsp_ch.chunk_length !== want.length) begin
                  $display("%0t chunk_length mismatch: expected %0d, actual %0d", $time,
                           want.length, rsp_ch.chunk_length);
                  failures++;
               end
               if (rsp_ch.config_error !== want.err) begin
                  $display("%0t config_error mismatch: expected %b, actual %b", $time,
                           want.err, rsp_ch.config_error);
                  failures++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!long_hold_done && chunks_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 17);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Main sequence: directed cases, then random phases of settings and data sets.
   initial begin
      int random_items;
      int sets;
      int len;
      int unsigned fac;
      bit open_end;
      random_items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Byte extremes under the reset setting, then a one-byte block.
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h55, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hAA, 1'b0);
      push_byte(8'h3C, 1'b0);
      drain();

      // Factor changed while a block is open: the window restarts, the block goes on.
      set_factor(5, 1'b1);
      push_byte(8'hC3, 1'b0);
      push_byte(8'h00, 1'b0);
      drain();

      // Largest factor, then an invalid factor while that block is still open.
      set_factor(255, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      drain();
      set_factor(0, 1'b0);
      push_byte(8'h12, 1'b0);
      push_byte(8'hFF, 1'b1);
      drain();
      set_factor(1, 1'b0);
      push_byte(8'h34, 1'b1);
      drain();
      set_factor(2, 1'b0);
      push_byte(8'h56, 1'b1);
      drain();
      set_factor(254, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h01, 1'b1);
      drain();

      // Weights of 0 and 254, mismatched to the factor.
      set_factor(3, 1'b0);
      write_csr(CSR_REMOVAL_WEIGHT, 0);
      push_set(6, 1'b1);
      drain();
      set_factor(7, 1'b0);
      write_csr(CSR_REMOVAL_WEIGHT, 254);
      push_set(12, 1'b1);
      drain();

      // First random phase keeps many short blocks queued for the long hold-off.
      set_factor(3, 1'b1);
      for (int s = 0; s < 3; s++) push_set(50, 1'b1);
      random_items += 150;
      drain();

      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         case ($urandom_range(0, 9))
            0: fac = $urandom_range(0, 1) ? 255 : $urandom_range(64, 127) * 2 + 1;
            1: fac = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(2, 127) * 2;
            default: fac = $urandom_range(1, 15) * 2 + 1;
         endcase
         if ($urandom_range(0, 3) != 0) begin
            write_csr(CSR_FACTOR, fac);
            if (factor_ok(fac)) begin
               if ($urandom_range(0, 4) != 0) write_csr(CSR_REMOVAL_WEIGHT, exit_weight(fac));
               else write_csr(CSR_REMOVAL_WEIGHT, $urandom_range(0, 254));
            end
         end
         if (!factor_ok(cur_factor)) begin
            push_set($urandom_range(1, 3), 1'b1);
         end else begin
            sets = $urandom_range(1, 4);
            for (int s = 0; s < sets; s++) begin
               if ($urandom_range(0, 7) == 0)
                  len = $urandom_range(cur_factor + 1, cur_factor + 120);
               else
                  len = $urandom_range(1, 48);
               open_end = (s == sets - 1) && ($urandom_range(0, 2) == 0);
               push_set(len, !open_end);
               random_items += len;
            end
         end
         drain();
      end

      drain();
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
